// ----- design/anbs_pkg.sv -----
package anbs_pkg;

  // Width of the byte position counter (saturating).
  localparam int POS_BITS = 32;

  localparam logic [2:0] LONG_PREFIX  = 3'd4;
  localparam logic [2:0] SHORT_PREFIX = 3'd3;
  localparam logic [4:0] TYPE_MASK    = 5'h1F;

  // Result buffer depth: room for a two-result byte plus slack.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [POS_BITS:0]   body_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic        unit_found;
    logic [31:0] unit_offset;
    logic [31:0] unit_length;
    logic [2:0]  prefix_length;
    logic [31:0] payload_length;
    logic [1:0]  ref_idc;
    logic [4:0]  unit_type;
    logic        at_stream_start;
    logic        at_stream_end;
    logic        last_of_run;
  } out_item_t;

  // Push strobes from the parser to the result buffer.
  typedef struct packed {
    logic first;
    logic second;
  } res_push_t;

endpackage

// ----- design/anbs_parse.sv -----
module anbs_parse import anbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  logic      room,
  output res_push_t push,
  output out_item_t res_first,
  output out_item_t res_second
);

  logic       item_valid_r, item_valid_nxt;
  in_item_t   item_r;

  pos_t       pos_r, pos_nxt;
  logic [1:0] zrun_r, zrun_nxt;
  logic       cand_r, cand_nxt;
  pos_t       cand_off_r, cand_off_nxt;
  body_t      cand_body_r, cand_body_nxt;
  logic       cand_long_r, cand_long_nxt;
  logic       open_r, open_nxt;
  pos_t       open_off_r, open_off_nxt;
  body_t      open_body_r, open_body_nxt;
  logic       open_long_r, open_long_nxt;
  logic [7:0] open_hdr_r, open_hdr_nxt;

  logic       go;
  logic       close_unit;
  logic       is_start;
  pos_t       end_fin;
  out_item_t  close_res;
  out_item_t  fin_res;

  // Body start is one past the 01 byte, so payload = end - body.
  function automatic out_item_t build_unit(pos_t off, body_t body, logic is_long,
                                           logic [7:0] hdr, pos_t end_off, logic at_end);
    out_item_t r;
    r = '0;
    r.unit_found      = 1'b1;
    r.unit_offset     = 32'(off);
    r.unit_length     = (end_off >= off) ? 32'(end_off - off) : 32'd0;
    r.prefix_length   = is_long ? LONG_PREFIX : SHORT_PREFIX;
    r.payload_length  = ({1'b0, end_off} >= body) ? 32'({1'b0, end_off} - body) : 32'd0;
    r.ref_idc         = hdr[6:5];
    r.unit_type       = hdr[4:0] & TYPE_MASK;
    r.at_stream_start = (off == '0);
    r.at_stream_end   = at_end;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

  assign go       = item_valid_r && room;
  assign in_stall = item_valid_r && !room;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (!in_stall) begin
      item_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= in_data;
    end
  end

  assign close_unit = cand_r && open_r;
  assign is_start   = (item_r.data_byte == 8'h01) && (zrun_r >= 2'd2);
  assign end_fin    = (pos_r == '1) ? pos_r : pos_r + pos_t'(1);

  always_comb begin
    // Adopt the pending start code; its header byte is this byte.
    open_nxt      = open_r | cand_r;
    open_off_nxt  = cand_r ? cand_off_r  : open_off_r;
    open_body_nxt = cand_r ? cand_body_r : open_body_r;
    open_long_nxt = cand_r ? cand_long_r : open_long_r;
    open_hdr_nxt  = cand_r ? item_r.data_byte : open_hdr_r;

    close_res = build_unit(open_off_r, open_body_r, open_long_r, open_hdr_r,
                           cand_off_r, 1'b0);
    if (open_nxt) begin
      fin_res = build_unit(open_off_nxt, open_body_nxt, open_long_nxt, open_hdr_nxt,
                           end_fin, 1'b1);
    end else begin
      fin_res = '0;
    end
    fin_res.last_of_run = 1'b1;

    if (item_r.data_byte == 8'h00) begin
      zrun_nxt = (zrun_r == 2'd3) ? zrun_r : zrun_r + 2'd1;
    end else begin
      zrun_nxt = 2'd0;
    end
    cand_nxt      = is_start;
    cand_long_nxt = is_start ? (zrun_r == 2'd3) : cand_long_r;
    cand_off_nxt  = is_start ? (pos_r - ((zrun_r == 2'd3) ? pos_t'(3) : pos_t'(2)))
                             : cand_off_r;
    cand_body_nxt = is_start ? ({1'b0, pos_r} + body_t'(1)) : cand_body_r;
    pos_nxt       = (pos_r == '1) ? pos_r : pos_r + pos_t'(1);

    push.first  = go && (close_unit || item_r.final_byte);
    push.second = go && close_unit && item_r.final_byte;
    res_second  = fin_res;
    res_first   = close_res;
    if (close_unit) begin
      res_first.last_of_run = !item_r.final_byte;
    end else begin
      res_first = fin_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && item_r.final_byte)) begin
      pos_r       <= '0;
      zrun_r      <= '0;
      cand_r      <= 1'b0;
      cand_off_r  <= '0;
      cand_body_r <= '0;
      cand_long_r <= 1'b0;
      open_r      <= 1'b0;
      open_off_r  <= '0;
      open_body_r <= '0;
      open_long_r <= 1'b0;
      open_hdr_r  <= '0;
    end else if (go) begin
      pos_r       <= pos_nxt;
      zrun_r      <= zrun_nxt;
      cand_r      <= cand_nxt;
      cand_off_r  <= cand_off_nxt;
      cand_body_r <= cand_body_nxt;
      cand_long_r <= cand_long_nxt;
      open_r      <= open_nxt;
      open_off_r  <= open_off_nxt;
      open_body_r <= open_body_nxt;
      open_long_r <= open_long_nxt;
      open_hdr_r  <= open_hdr_nxt;
    end
  end

endmodule

// ----- design/anbs_out_fifo.sv -----
module anbs_out_fifo import anbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_push_t push,
  input  out_item_t res_first,
  input  out_item_t res_second,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t          slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               pop;
  logic [FIFO_AW-1:0] wr_ptr_p1;
  logic [FIFO_AW:0]   n_push;

  assign out_valid = (count_r != '0);
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // Two free slots needed: one byte may push two results.
  assign room      = (count_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + FIFO_AW'(1);

  always_comb begin
    n_push     = (FIFO_AW+1)'(push.first) + (FIFO_AW+1)'(push.second);
    wr_ptr_nxt = wr_ptr_r + n_push[FIFO_AW-1:0];
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + n_push - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      slot_r[wr_ptr_r] <= res_first;
    end
    if (push.second) begin
      slot_r[wr_ptr_p1] <= res_second;
    end
  end

endmodule

// ----- design/annexb_nal_unit_splitter.sv -----
// H.264 Annex B NAL unit splitter. Feed the byte stream one byte per input
// transaction and mark the last byte of each buffer with final_byte; offsets restart
// at zero for the byte after it. A unit is reported once its end is known (the next
// start code's header byte, or the last byte), so results trail the bytes that
// define them. A byte yields zero, one or two results; last_of_run marks the last
// result of a byte. A buffer with no start code yields one result with
// unit_found = 0. Note that ref_idc carries header bits 6:5. The block takes one byte
// per clock while its four-entry result buffer has two free slots, and the result
// side drains one result per clock while out_stall is low; a result's byte passes
// the parser's input register, and the result then waits in the result buffer.
module annexb_nal_unit_splitter import anbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  res_push_t push;
  out_item_t res_first;
  out_item_t res_second;
  logic      room;

  // Hold the byte in the input register and parse it when the buffer has room.
  anbs_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .room       (room),
    .push       (push),
    .res_first  (res_first),
    .res_second (res_second)
  );

  // Queue results so a stalled output does not block parsing right away.
  anbs_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .res_first  (res_first),
    .res_second (res_second),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- tb/tb_annexb_nal_unit_splitter.sv -----
`timescale 1ns / 1ps

module tb_annexb_nal_unit_splitter;
  import anbs_pkg::*;

  // Largest value of the saturating byte position.
  localparam logic [63:0] POS_LIMIT = (64'd1 << POS_BITS) - 64'd1;
  // Length of the long receiver hold-off, in cycles.
  localparam int LONG_HOLD = 400;
  // Random bytes per phase; three phases give about 1800.
  localparam int PHASE_BYTES = 600;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  annexb_nal_unit_splitter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stream bytes waiting to be offered, and NAL unit reports still owed by the block.
  in_item_t  pending_bytes[$];
  out_item_t units_expected[$];

  // Idle percentages per side; changed only between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long hold-off request from the stimulus; the receiver counts it out itself.
  logic long_hold_req = 1'b0;
  int   hold_count = 0;

  logic in_took = 1'b0;
  int   errors = 0;
  int   bytes_seen = 0;
  int   buffers_seen = 0;
  int   results_seen = 0;
  int   empty_reports = 0;
  int   two_unit_bytes = 0;

  // Shadow of the splitter's state.
  logic [POS_BITS-1:0] byte_pos = '0;
  logic [1:0]          zero_run = '0;
  logic                cand_pending = 1'b0;
  logic [63:0]         cand_offset = '0;
  logic                cand_long = 1'b0;
  logic                unit_open = 1'b0;
  logic [63:0]         open_offset = '0;
  logic [7:0]          open_header = '0;
  logic                open_long = 1'b0;

  // Build the report for the open unit, ending just before end_off.
  function automatic out_item_t close_unit(input logic [63:0] end_off, input logic at_end);
    out_item_t   r;
    logic [63:0] len;
    logic [63:0] pre;
    logic [63:0] pay;
    len = (end_off >= open_offset) ? end_off - open_offset : 64'd0;
    pre = open_long ? 64'(LONG_PREFIX) : 64'(SHORT_PREFIX);
    pay = (len >= pre) ? len - pre : 64'd0;
    r = '0;
    r.unit_found      = 1'b1;
    r.unit_offset     = open_offset[31:0];
    r.unit_length     = len[31:0];
    r.prefix_length   = open_long ? LONG_PREFIX : SHORT_PREFIX;
    r.payload_length  = pay[31:0];
    // nal_ref_idc sits in header bits 6:5 here
    r.ref_idc         = open_header[6:5];
    r.unit_type       = open_header[4:0] & TYPE_MASK;
    r.at_stream_start = (open_offset == 64'd0);
    r.at_stream_end   = at_end;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

  // Advance the shadow state by one byte and queue the unit reports it causes.
  task automatic predict_units(input in_item_t item);
    logic [63:0] pos;
    logic [7:0]  b;
    out_item_t   res[2];
    int          n;
    pos = 64'(byte_pos);
    b = item.data_byte;
    n = 0;
    // A pending start code is confirmed by this header byte: close the old unit.
    if (cand_pending) begin
      if (unit_open) begin
        res[n] = close_unit(cand_offset, 1'b0);
        n++;
      end
      unit_open = 1'b1;
      open_offset = cand_offset;
      open_long = cand_long;
      open_header = b;
      cand_pending = 1'b0;
    end
    // Track zeros; a 01 after two or more zeros becomes a candidate start code.
    if (b == 8'h00) begin
      if (zero_run < 2'd3) zero_run++;
    end else begin
      if (b == 8'h01 && zero_run >= 2'd2) begin
        cand_pending = 1'b1;
        cand_long = (zero_run == 2'd3);
        cand_offset = pos - (cand_long ? 64'd3 : 64'd2);
      end
      zero_run = '0;
    end
    // Last byte of the buffer: report what is open (or nothing found), then clear.
    if (item.final_byte) begin
      if (unit_open) begin
        res[n] = close_unit((pos == POS_LIMIT) ? pos : pos + 64'd1, 1'b1);
      end else begin
        res[n] = '0;
      end
      n++;
      byte_pos = '0;
      zero_run = '0;
      cand_pending = 1'b0;
      cand_offset = '0;
      cand_long = 1'b0;
      unit_open = 1'b0;
      open_offset = '0;
      open_header = '0;
      open_long = 1'b0;
    end else if (64'(byte_pos) < POS_LIMIT) begin
      byte_pos++;
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    if (n == 2) two_unit_bytes++;
    for (int i = 0; i < n; i++) units_expected.push_back(res[i]);
  endtask

  task automatic compare_unit(input out_item_t got, input out_item_t want);
    if (got.unit_found !== want.unit_found) begin
      $error("unit_found: expected %0d, got %0d", want.unit_found, got.unit_found);
      errors++;
    end
    if (got.unit_offset !== want.unit_offset) begin
      $error("unit_offset: expected %0d, got %0d", want.unit_offset, got.unit_offset);
      errors++;
    end
    if (got.unit_length !== want.unit_length) begin
      $error("unit_length: expected %0d, got %0d", want.unit_length, got.unit_length);
      errors++;
    end
    if (got.prefix_length !== want.prefix_length) begin
      $error("prefix_length: expected %0d, got %0d", want.prefix_length, got.prefix_length);
      errors++;
    end
    if (got.payload_length !== want.payload_length) begin
      $error("payload_length: expected %0d, got %0d", want.payload_length,
             got.payload_length);
      errors++;
    end
    if (got.ref_idc !== want.ref_idc) begin
      $error("ref_idc: expected %0d, got %0d", want.ref_idc, got.ref_idc);
      errors++;
    end
    if (got.unit_type !== want.unit_type) begin
      $error("unit_type: expected %0d, got %0d", want.unit_type, got.unit_type);
      errors++;
    end
    if (got.at_stream_start !== want.at_stream_start) begin
      $error("at_stream_start: expected %0d, got %0d", want.at_stream_start,
             got.at_stream_start);
      errors++;
    end
    if (got.at_stream_end !== want.at_stream_end) begin
      $error("at_stream_end: expected %0d, got %0d", want.at_stream_end, got.at_stream_end);
      errors++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
      errors++;
    end
  endtask

  // Driver: hold the current byte until it is taken, then offer the next one
  // or idle. Valid depends only on the queue and the idle draw, never on stall.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: on request stall without a break until hold_count reaches LONG_HOLD,
  // otherwise stall at random per the current phase.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold_req && hold_count < LONG_HOLD) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: predict on each input transaction first, then check the output
  // transaction of the same edge, so the order of processes never matters.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_units(in_data);
        bytes_seen++;
        if (in_data.final_byte) buffers_seen++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (!out_data.unit_found) empty_reports++;
        if (units_expected.size() == 0) begin
          $error("result with nothing expected: offset %0d, length %0d",
                 out_data.unit_offset, out_data.unit_length);
          errors++;
        end else begin
          want = units_expected.pop_front();
          compare_unit(out_data, want);
        end
      end
    end
  end

  task automatic push_seq(input logic [7:0] seq[$]);
    in_item_t item;
    for (int i = 0; i < seq.size(); i++) begin
      item.data_byte = seq[i];
      item.final_byte = (i == seq.size() - 1);
      pending_bytes.push_back(item);
    end
  endtask

  // Zero-heavy byte mix so that stray start codes show up inside payloads.
  function automatic logic [7:0] noise_byte();
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) return 8'h00;
    if (pick == 3) return 8'h01;
    return 8'($urandom_range(255));
  endfunction

  // Mostly well-formed buffers (junk, then units with 3/4-byte codes and runs
  // of extra zeros, sometimes cut right after the 01), plus raw noise buffers.
  task automatic queue_random_buffer(inout int added);
    logic [7:0] seq[$];
    int         units;
    if ($urandom_range(99) < 80) begin
      repeat ($urandom_range(3)) seq.push_back(noise_byte());
      units = $urandom_range(1, 4);
      for (int u = 0; u < units; u++) begin
        repeat ($urandom_range(2, 5)) seq.push_back(8'h00);
        seq.push_back(8'h01);
        if (u == units - 1 && $urandom_range(9) == 0) break;
        seq.push_back(8'($urandom_range(255)));
        repeat ($urandom_range(12)) seq.push_back(noise_byte());
      end
    end else begin
      repeat ($urandom_range(1, 20)) seq.push_back(noise_byte());
    end
    added += seq.size();
    push_seq(seq);
  endtask

  task automatic drain();
    while (pending_bytes.size() > 0 || in_valid || units_expected.size() > 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] seq[$];
    int         added;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Phase 1: sender idles 35%, receiver 52%.
    send_idle_pct = 35;
    recv_idle_pct = 52;

    // Single byte, no start code: one not-found report.
    seq = '{8'h00};
    push_seq(seq);
    // Start code cut off before its header byte: still nothing found.
    seq = '{8'h00, 8'h00, 8'h01};
    push_seq(seq);
    // Shortest unit: 3-byte code at offset zero, header on the last byte.
    seq = '{8'h00, 8'h00, 8'h01, 8'h65};
    push_seq(seq);
    // Junk byte, 4-byte code with all-ones header, then a 3-byte code whose
    // header is the last byte: two reports from that byte.
    seq = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00};
    push_seq(seq);
    // Five zeros before the 01: long code starts three bytes before the 01.
    seq = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41, 8'h80};
    push_seq(seq);

    added = 0;
    while (added < PHASE_BYTES) queue_random_buffer(added);
    drain();

    // Phase 2: roles swapped.
    send_idle_pct = 52;
    recv_idle_pct = 35;
    added = 0;
    while (added < PHASE_BYTES) queue_random_buffer(added);
    drain();

    // Phase 3: no idling; start with a long receiver hold-off while the
    // sender keeps offering, so the result buffer fills and input stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    added = 0;
    while (added < PHASE_BYTES) queue_random_buffer(added);
    long_hold_req = 1'b1;
    drain();

    // Let any stray result show up before the verdict.
    repeat (20) @(posedge clk);
    if (units_expected.size() > 0) begin
      $error("%0d expected results never arrived", units_expected.size());
      errors++;
    end
    $display("Covered %0d bytes in %0d buffers: %0d reports checked, %0d empty-buffer,",
             bytes_seen, buffers_seen, results_seen, empty_reports);
    $display("%0d bytes closing one unit and opening another at buffer end; %0d errors",
             two_unit_bytes, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
